[hw/rtl/slbs_pkg.sv]
// ----------------------------------------------------------------------------
// Status LED blink sequencer package
// Shared widths, constants, codes and the blinker control word.
// ----------------------------------------------------------------------------
package slbs_pkg;

    // One tick in milliseconds.
    localparam int TICK_MS = 5;
    localparam int TICK_W  = $clog2(TICK_MS + 1);

    localparam int DUR_W        = 16;
    localparam int PERIOD_W     = 16;
    localparam int DUTY_W       = 9;
    localparam int TICKS_W      = 14;
    localparam int PHASE_W      = 16;
    localparam int SAT_PERIOD_W = 13;
    localparam int SAT_W        = 6;
    localparam int MODE_W       = 3;
    localparam int FACE_W       = 3;
    localparam int STEP_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Input word opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Run modes.
    localparam logic [MODE_W-1:0] MODE_ALL_BLINK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACCEL_CAL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAG_CAL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ALL_HIGH  = 3'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY           = 3'd4;

    // Register reset values.
    localparam int DEF_START_MS = 2000;
    localparam logic [PERIOD_W-1:0] DEF_PERIOD_ONE   = 16'd200;
    localparam logic [PERIOD_W-1:0] DEF_PERIOD_TWO   = 16'd500;
    localparam logic [PERIOD_W-1:0] DEF_PERIOD_THREE = 16'd800;
    localparam logic [DUTY_W-1:0]   DEF_DUTY         = 9'd128;
    localparam logic [TICKS_W-1:0]  DEF_START_TICKS  = TICKS_W'(DEF_START_MS / TICK_MS);

    // Satellite pin schedule.
    localparam logic [SAT_W-1:0] SAT_FEW_MAX = 6'd5;
    localparam logic [SAT_W-1:0] SAT_MID_MAX = 6'd9;
    localparam logic [SAT_PERIOD_W-1:0] SAT_PERIOD_FAST = 13'd1000;
    localparam logic [SAT_PERIOD_W-1:0] SAT_PERIOD_MID  = 13'd2000;
    localparam logic [SAT_PERIOD_W-1:0] SAT_PERIOD_SLOW = 13'd5000;
    localparam logic [TICKS_W-1:0] SAT_TICKS_SHORT = TICKS_W'(1000 / TICK_MS);
    localparam logic [TICKS_W-1:0] SAT_TICKS_LONG  = TICKS_W'(2000 / TICK_MS);
    localparam logic [DUTY_W-1:0]  SAT_DUTY        = 9'd128;

    // Reciprocal for dividing a duration by the tick length.
    localparam int DIV_SHIFT  = DUR_W + $clog2(TICK_MS);
    localparam int DIV_MULT_W = DUR_W + 1;
    localparam int DIV_PROD_W = DUR_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((64'd1 << DIV_SHIFT) + TICK_MS - 1) / TICK_MS);

    typedef struct packed {
        logic               load;
        logic [TICKS_W-1:0] load_ticks;
        logic               load_endless;
        logic               advance;
        logic               force_high;
    } blk_ctrl_t;

endpackage

[hw/rtl/status_led_blink_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Status LED blink sequencer core
// Four pin blinkers stepped by tick and start words, one result per word.
// ----------------------------------------------------------------------------
// Each input word (a 5 ms tick or a start command) yields one output word with
// the four pin levels after that word. A word is registered on acceptance and
// processed into the output register once that register is free or being read,
// so the core sustains one word per clock while results are taken; the logic
// between the registers is the mode decode, satellite reload and blinker update,
// whose longest path is the period-times-duty product and its compare. A new word
// is taken while the previous result still waits on the output. Configuration
// writes take effect at once and must only be made while no word is in flight.
module status_led_blink_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [slbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] run_mode, [5:3] accel_face, [7:6] mag_step, [13:8] sat_count,
    // [19:14] prev_sat_count, [20] filter_failed, [23:21] zero.
    input  logic [23:0]                       s_tdata,
    // [0] opcode.
    input  logic                              s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] pin_one, [1] pin_two, [2] pin_three, [3] pin_four, [7:4] zero.
    output logic [7:0]                        m_tdata
);
    import slbs_pkg::*;

    // Configuration registers.
    logic [TICKS_W-1:0]  start_ticks_reg;
    logic [PERIOD_W-1:0] period_reg [3];
    logic [DUTY_W-1:0]   duty_reg;
    logic [DIV_PROD_W-1:0] div_prod;

    // Input register.
    logic               in_valid_reg;
    logic               op_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [FACE_W-1:0]  face_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SAT_W-1:0]   sats_reg;
    logic [SAT_W-1:0]   prev_reg;
    logic               failed_reg;

    // Output register.
    logic       m_tvalid_reg;
    logic [3:0] pins_reg;

    logic       take;
    logic       is_start;
    logic       touch;
    logic [2:0] blink_mask;
    logic       changed;
    logic       reload;
    logic [TICKS_W-1:0]      reload_ticks;
    logic [SAT_PERIOD_W-1:0] sat_period_reg, sat_period_next;
    blk_ctrl_t  ctrl [4];
    logic [3:0] pin_next;

    function automatic logic [2:0] face_mask(input logic [FACE_W-1:0] face);
        case (face)
            3'd0:    face_mask = 3'b001;
            3'd1:    face_mask = 3'b010;
            3'd2:    face_mask = 3'b011;
            3'd3:    face_mask = 3'b100;
            3'd4:    face_mask = 3'b101;
            3'd5:    face_mask = 3'b110;
            default: face_mask = 3'b111;
        endcase
    endfunction

    function automatic logic [2:0] step_mask(input logic [STEP_W-1:0] step);
        case (step)
            2'd0:    step_mask = 3'b001;
            2'd1:    step_mask = 3'b010;
            2'd2:    step_mask = 3'b100;
            default: step_mask = 3'b111;
        endcase
    endfunction

    // Duration to ticks by reciprocal multiplication; exact over the 16-bit range.
    assign div_prod = DIV_PROD_W'(cfg_wdata) * DIV_PROD_W'(DIV_MULT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ticks_reg <= DEF_START_TICKS;
            period_reg[0]   <= DEF_PERIOD_ONE;
            period_reg[1]   <= DEF_PERIOD_TWO;
            period_reg[2]   <= DEF_PERIOD_THREE;
            duty_reg        <= DEF_DUTY;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_START_DURATION: start_ticks_reg <= TICKS_W'(div_prod >> DIV_SHIFT);
                REG_PERIOD_ONE:     period_reg[0]   <= cfg_wdata;
                REG_PERIOD_TWO:     period_reg[1]   <= cfg_wdata;
                REG_PERIOD_THREE:   period_reg[2]   <= cfg_wdata;
                REG_DUTY:           duty_reg        <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign take     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            mode_reg   <= s_tdata[2:0];
            face_reg   <= s_tdata[5:3];
            step_reg   <= s_tdata[7:6];
            sats_reg   <= s_tdata[13:8];
            prev_reg   <= s_tdata[19:14];
            failed_reg <= s_tdata[20];
        end
    end

    always_comb begin
        is_start = op_reg == OP_START;
        touch    = 1'b1;
        case (mode_reg)
            MODE_ALL_BLINK: blink_mask = 3'b111;
            MODE_ACCEL_CAL: blink_mask = face_mask(face_reg);
            MODE_MAG_CAL:   blink_mask = step_mask(step_reg);
            MODE_ALL_HIGH:  blink_mask = 3'b000;
            default: begin
                blink_mask = 3'b000;
                touch      = 1'b0;
            end
        endcase

        // Satellite pin reload; the first matching rule wins, and a start overrides them all.
        changed         = sats_reg != prev_reg;
        reload          = 1'b1;
        reload_ticks    = SAT_TICKS_LONG;
        sat_period_next = sat_period_reg;
        if ((changed && sats_reg <= SAT_FEW_MAX) || failed_reg) begin
            reload_ticks    = SAT_TICKS_SHORT;
            sat_period_next = SAT_PERIOD_FAST;
        end else if (changed && sats_reg <= SAT_MID_MAX) begin
            sat_period_next = SAT_PERIOD_MID;
        end else if (changed) begin
            sat_period_next = SAT_PERIOD_SLOW;
        end else begin
            reload = 1'b0;
        end
        if (is_start) begin
            reload          = 1'b0;
            sat_period_next = SAT_PERIOD_FAST;
        end

        for (int k = 0; k < 3; k++) begin
            ctrl[k].load         = is_start;
            ctrl[k].load_ticks   = start_ticks_reg;
            ctrl[k].load_endless = 1'b0;
            ctrl[k].advance      = !is_start && touch && blink_mask[k];
            ctrl[k].force_high   = !is_start && touch && !blink_mask[k];
        end
        ctrl[3].load         = is_start || reload;
        ctrl[3].load_ticks   = is_start ? start_ticks_reg : reload_ticks;
        ctrl[3].load_endless = 1'b1;
        ctrl[3].advance      = !is_start;
        ctrl[3].force_high   = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_period_reg <= '0;
        end else if (take) begin
            sat_period_reg <= sat_period_next;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_status_pin
        slbs_blinker u_blinker (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (take),
            .ctrl     (ctrl[g]),
            .period   (period_reg[g]),
            .duty     (duty_reg),
            .pin_next (pin_next[g])
        );
    end

    slbs_blinker u_sat_blinker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (take),
        .ctrl     (ctrl[3]),
        .period   (PERIOD_W'(sat_period_next)),
        .duty     (SAT_DUTY),
        .pin_next (pin_next[3])
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pins_reg <= pin_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, pins_reg};

endmodule

[hw/rtl/slbs_blinker.sv]
// ----------------------------------------------------------------------------
// Status LED blinker
// State of one pin blinker, with its load, countdown and phase logic.
// ----------------------------------------------------------------------------
module slbs_blinker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  slbs_pkg::blk_ctrl_t            ctrl,
    input  logic [slbs_pkg::PERIOD_W-1:0]  period,
    input  logic [slbs_pkg::DUTY_W-1:0]    duty,
    output logic                           pin_next
);
    import slbs_pkg::*;

    localparam int SCALED_W = PHASE_W + TICK_W;
    localparam int LEVEL_W  = SCALED_W + 8;
    localparam int THR_W    = PERIOD_W + DUTY_W;

    logic [TICKS_W-1:0]  remaining_reg, remaining_next, rem_ld;
    logic [PHASE_W-1:0]  phase_reg, phase_next, phase_ld, phase_inc, phase_wrap;
    logic                endless_reg, endless_next;
    logic                pin_reg, pin_ld;
    logic [SCALED_W-1:0] scaled_inc, scaled_wrap;
    logic [THR_W-1:0]    threshold;
    logic                wrap;

    always_comb begin
        rem_ld       = ctrl.load ? ctrl.load_ticks : remaining_reg;
        phase_ld     = ctrl.load ? '0 : phase_reg;
        endless_next = ctrl.load ? ctrl.load_endless : endless_reg;
        pin_ld       = pin_reg;

        phase_inc   = phase_ld + 1'b1;
        scaled_inc  = SCALED_W'(phase_inc) * SCALED_W'(TICK_MS);
        wrap        = scaled_inc >= SCALED_W'(period);
        phase_wrap  = wrap ? '0 : phase_inc;
        scaled_wrap = wrap ? '0 : scaled_inc;
        threshold   = THR_W'(period) * THR_W'(duty);

        remaining_next = rem_ld;
        phase_next     = phase_ld;
        pin_next       = pin_ld;

        if (ctrl.force_high) begin
            pin_next = 1'b1;
        end else if (ctrl.advance) begin
            if (rem_ld != '0) begin
                remaining_next = rem_ld - 1'b1;
            end else begin
                pin_next = 1'b1;
            end
            // The phase only runs while the countdown is live or the blinker is endless.
            if (remaining_next != '0 || endless_next) begin
                phase_next = phase_wrap;
                pin_next   = {scaled_wrap, 8'b0} <= LEVEL_W'(threshold);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            phase_reg     <= '0;
            endless_reg   <= 1'b0;
            pin_reg       <= 1'b0;
        end else if (step_en) begin
            remaining_reg <= remaining_next;
            phase_reg     <= phase_next;
            endless_reg   <= endless_next;
            pin_reg       <= pin_next;
        end
    end

endmodule
